FILE: rtl/core/lrbt_pkg.sv
package lrbt_pkg;

  // model size, fixed by the 7-bit coefficient index
  localparam int NUM_VARS        = 64;
  localparam int SIG_ENTRIES_DEF = 256;
  localparam int POS_W           = $clog2(NUM_VARS + 1);
  localparam int FADDR_W         = $clog2(NUM_VARS);
  localparam int IDX_W           = 7;
  localparam logic [15:0] LR_RESET = 16'd655;

  // request codes
  localparam logic [1:0] REQ_FEATURE = 2'd0;
  localparam logic [1:0] REQ_STEP    = 2'd1;
  localparam logic [1:0] REQ_WRITE   = 2'd2;
  localparam logic [1:0] REQ_READ    = 2'd3;

  // response codes
  localparam logic [1:0] RESP_PRED  = 2'd0;
  localparam logic [1:0] RESP_STEP  = 2'd1;
  localparam logic [1:0] RESP_RDATA = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic cap_in;
    logic wr;
    logic s_init;
    logic f_rd;
    logic f_mul;
    logic f_acc;
    logic z_rd;
    logic z_add;
    logic sig;
    logic u_rd;
    logic u_mul;
    logic u_acc;
    logic ub_rd;
    logic ub_acc;
    logic s_rd;
    logic s_mul;
    logic s_acc;
    logic s_done;
    logic r_rd;
    logic r_done;
    logic push;
  } lrbt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req;
    logic       last;
    logic       pos_full;
    logic       pos_zero;
    logic       u_last;
    logic       s_last;
    logic       out_free;
  } lrbt_sts_t;

  // saturate a 49-bit sum to 48 bits
  function automatic logic signed [47:0] lrbt_sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) begin
      return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    return v[47:0];
  endfunction

  // saturate a 49-bit sum to 32 bits
  function automatic logic signed [31:0] lrbt_sat32(input logic signed [48:0] v);
    if (v[48:31] != {18{v[48]}}) begin
      return v[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] lrbt_udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid at midpoint m (Q16.16), result Q0.16
  function automatic logic [15:0] lrbt_sig_entry(input longint m);
    logic [63:0] a;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] y3;
    logic [63:0] p;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] s;
    a = (m < 0) ? 64'(-m) : 64'(m);
    if (a == 64'd0) begin
      e = 64'd1 << 32;
    end else begin
      y  = a << 8;
      y2 = (y * y) >> 32;
      y3 = (y2 * y) >> 32;
      p  = (64'd1 << 32) - y + (y2 >> 1) - lrbt_udiv64(y3, 64'd6);
      for (int k = 0; k < 8; k++) begin
        p = (p * p) >> 32;
      end
      e = p;
    end
    d = (64'd1 << 32) + e;
    if (m >= 0) begin
      s = lrbt_udiv64((64'd1 << 48) + (d >> 1), d);
      if (s > 64'd65535) begin
        s = 64'd65535;
      end
    end else begin
      s = lrbt_udiv64((e << 16) + (d >> 1), d);
    end
    return s[15:0];
  endfunction

endpackage

FILE: rtl/core/lrbt_if.sv
// request channel
interface lrbt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] feature_value;
  logic               last_feature;
  logic               truth;
  logic [6:0]         coeff_index;
  logic signed [31:0] coeff_value;

  modport source (output valid, req_type, feature_value, last_feature, truth,
                  coeff_index, coeff_value, input ready);
  modport sink (input valid, req_type, feature_value, last_feature, truth,
                coeff_index, coeff_value, output ready);
endinterface

// result channel
interface lrbt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         resp_kind;
  logic               predicted_class;
  logic signed [31:0] coeff_data;
  logic signed [47:0] total_change;
  logic [15:0]        true_pos;
  logic [15:0]        false_pos;
  logic [15:0]        false_neg;
  logic [15:0]        true_neg;

  modport source (output valid, resp_kind, predicted_class, coeff_data, total_change,
                  true_pos, false_pos, false_neg, true_neg, input ready);
  modport sink (input valid, resp_kind, predicted_class, coeff_data, total_change,
                true_pos, false_pos, false_neg, true_neg, output ready);
endinterface

FILE: rtl/core/lrbt_ctrl.sv
module lrbt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lrbt_pkg::lrbt_sts_t   sts,
  output lrbt_pkg::lrbt_cmd_t   cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DISP   = 5'd1;
  localparam logic [4:0] ST_F_RD   = 5'd2;
  localparam logic [4:0] ST_F_MUL  = 5'd3;
  localparam logic [4:0] ST_F_ACC  = 5'd4;
  localparam logic [4:0] ST_Z_RD   = 5'd5;
  localparam logic [4:0] ST_Z_ADD  = 5'd6;
  localparam logic [4:0] ST_SIG    = 5'd7;
  localparam logic [4:0] ST_U_RD   = 5'd8;
  localparam logic [4:0] ST_U_MUL  = 5'd9;
  localparam logic [4:0] ST_U_ACC  = 5'd10;
  localparam logic [4:0] ST_UB_RD  = 5'd11;
  localparam logic [4:0] ST_UB_ACC = 5'd12;
  localparam logic [4:0] ST_S_RD   = 5'd13;
  localparam logic [4:0] ST_S_MUL  = 5'd14;
  localparam logic [4:0] ST_S_ACC  = 5'd15;
  localparam logic [4:0] ST_S_DONE = 5'd16;
  localparam logic [4:0] ST_R_RD   = 5'd17;
  localparam logic [4:0] ST_R_DONE = 5'd18;
  localparam logic [4:0] ST_PUSH   = 5'd19;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        case (sts.req)
          lrbt_pkg::REQ_FEATURE: begin
            if (!sts.pos_full)  state_nxt = ST_F_RD;
            else if (sts.last)  state_nxt = ST_Z_RD;
            else                state_nxt = ST_IDLE;
          end
          lrbt_pkg::REQ_STEP:  state_nxt = ST_S_RD;
          lrbt_pkg::REQ_WRITE: state_nxt = ST_IDLE;
          default:             state_nxt = ST_R_RD;
        endcase
      end
      ST_F_RD:   state_nxt = ST_F_MUL;
      ST_F_MUL:  state_nxt = ST_F_ACC;
      ST_F_ACC:  state_nxt = sts.last ? ST_Z_RD : ST_IDLE;
      ST_Z_RD:   state_nxt = ST_Z_ADD;
      ST_Z_ADD:  state_nxt = ST_SIG;
      ST_SIG:    state_nxt = sts.pos_zero ? ST_UB_RD : ST_U_RD;
      ST_U_RD:   state_nxt = ST_U_MUL;
      ST_U_MUL:  state_nxt = ST_U_ACC;
      ST_U_ACC:  state_nxt = sts.u_last ? ST_UB_RD : ST_U_RD;
      ST_UB_RD:  state_nxt = ST_UB_ACC;
      ST_UB_ACC: state_nxt = ST_PUSH;
      ST_S_RD:   state_nxt = ST_S_MUL;
      ST_S_MUL:  state_nxt = ST_S_ACC;
      ST_S_ACC:  state_nxt = sts.s_last ? ST_S_DONE : ST_S_RD;
      ST_S_DONE: state_nxt = ST_PUSH;
      ST_R_RD:   state_nxt = ST_R_DONE;
      ST_R_DONE: state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.cap_in = in_valid && (state_r == ST_IDLE);
    cmd.wr     = (state_r == ST_DISP) && (sts.req == lrbt_pkg::REQ_WRITE);
    cmd.s_init = (state_r == ST_DISP) && (sts.req == lrbt_pkg::REQ_STEP);
    cmd.f_rd   = (state_r == ST_F_RD);
    cmd.f_mul  = (state_r == ST_F_MUL);
    cmd.f_acc  = (state_r == ST_F_ACC);
    cmd.z_rd   = (state_r == ST_Z_RD);
    cmd.z_add  = (state_r == ST_Z_ADD);
    cmd.sig    = (state_r == ST_SIG);
    cmd.u_rd   = (state_r == ST_U_RD);
    cmd.u_mul  = (state_r == ST_U_MUL);
    cmd.u_acc  = (state_r == ST_U_ACC);
    cmd.ub_rd  = (state_r == ST_UB_RD);
    cmd.ub_acc = (state_r == ST_UB_ACC);
    cmd.s_rd   = (state_r == ST_S_RD);
    cmd.s_mul  = (state_r == ST_S_MUL);
    cmd.s_acc  = (state_r == ST_S_ACC);
    cmd.s_done = (state_r == ST_S_DONE);
    cmd.r_rd   = (state_r == ST_R_RD);
    cmd.r_done = (state_r == ST_R_DONE);
    cmd.push   = (state_r == ST_PUSH);
  end

endmodule

FILE: rtl/core/lrbt_dp.sv
module lrbt_dp #(
  parameter int SIGMOID_ENTRIES = lrbt_pkg::SIG_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  lrbt_pkg::lrbt_cmd_t cmd,
  output lrbt_pkg::lrbt_sts_t sts,
  input  logic [1:0]          in_req_type,
  input  logic signed [15:0]  in_feature_value,
  input  logic                in_last_feature,
  input  logic                in_truth,
  input  logic [6:0]          in_coeff_index,
  input  logic signed [31:0]  in_coeff_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_resp_kind,
  output logic                out_predicted_class,
  output logic signed [31:0]  out_coeff_data,
  output logic signed [47:0]  out_total_change,
  output logic [15:0]         out_true_pos,
  output logic [15:0]         out_false_pos,
  output logic [15:0]         out_false_neg,
  output logic [15:0]         out_true_neg
);

  localparam int NV     = lrbt_pkg::NUM_VARS;
  localparam int POS_W  = lrbt_pkg::POS_W;
  localparam int FA_W   = lrbt_pkg::FADDR_W;
  localparam int SIW    = $clog2(SIGMOID_ENTRIES);
  localparam int SPW    = 20 + $clog2(SIGMOID_ENTRIES + 1);
  localparam logic [POS_W-1:0] BIAS_SLOT = POS_W'(NV);

  // captured request
  logic [1:0]         req_r;
  logic signed [15:0] x_r;
  logic               last_r;
  logic               truth_r;
  logic [6:0]         cidx_r;
  logic signed [31:0] cval_r;
  logic               cidx_ok;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      req_r   <= in_req_type;
      x_r     <= in_feature_value;
      last_r  <= in_last_feature;
      truth_r <= in_truth;
      cidx_r  <= in_coeff_index;
      cval_r  <= in_coeff_value;
    end
  end

  assign cidx_ok = (cidx_r <= 7'(NV));

  // learning rate register
  logic [15:0] lr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= lrbt_pkg::LR_RESET;
    end else if (cfg_wr_en) begin
      lr_r <= cfg_wr_data;
    end
  end

  // example progress and loop counter
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   cnt_r;
  logic signed [47:0] dot_r;

  // coefficient memory with valid bits
  logic signed [31:0] coef_mem [NV+1];
  logic [NV:0]        coef_vld_r;
  logic signed [31:0] coef_q_r;
  logic               coef_qv_r;
  logic signed [31:0] coef_rd;
  logic               coef_re;
  logic [POS_W-1:0]   coef_ra;
  logic               coef_we;
  logic [POS_W-1:0]   coef_wa;
  logic signed [31:0] coef_wd;

  // batch accumulator memory with valid bits
  logic signed [47:0] bsum_mem [NV+1];
  logic [NV:0]        bsum_vld_r;
  logic signed [47:0] bsum_q_r;
  logic               bsum_qv_r;
  logic signed [47:0] bsum_rd;
  logic               bsum_re;
  logic [POS_W-1:0]   bsum_ra;
  logic               bsum_we;
  logic [POS_W-1:0]   bsum_wa;
  logic signed [47:0] bsum_wd;

  // feature buffer
  logic signed [15:0] fst_mem [NV];
  logic signed [15:0] fst_q_r;

  // arithmetic registers
  logic signed [47:0] prod_r;
  logic signed [47:0] z_r;
  logic signed [17:0] err_r;
  logic               cls_r;
  logic signed [33:0] prod2_r;
  logic signed [41:0] pl_r;
  logic signed [40:0] ph_r;
  logic signed [47:0] total_r;
  logic [15:0]        cnts_r [4];

  // step change
  logic signed [64:0] full_prod;
  logic signed [47:0] diff;
  assign full_prod = (65'(ph_r) <<< 24) + 65'(pl_r);
  assign diff      = full_prod[63:16];

  // coefficient port muxing
  always_comb begin
    coef_re = 1'b0;
    coef_ra = cnt_r;
    if (cmd.f_rd) begin
      coef_re = 1'b1;
      coef_ra = pos_r;
    end else if (cmd.z_rd) begin
      coef_re = 1'b1;
      coef_ra = BIAS_SLOT;
    end else if (cmd.s_rd) begin
      coef_re = 1'b1;
      coef_ra = cnt_r;
    end else if (cmd.r_rd && cidx_ok) begin
      coef_re = 1'b1;
      coef_ra = cidx_r[POS_W-1:0];
    end
    coef_we = 1'b0;
    coef_wa = cnt_r;
    coef_wd = lrbt_pkg::lrbt_sat32(49'(coef_rd) + 49'(diff));
    if (cmd.wr && cidx_ok) begin
      coef_we = 1'b1;
      coef_wa = cidx_r[POS_W-1:0];
      coef_wd = cval_r;
    end else if (cmd.s_acc) begin
      coef_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_wa] <= coef_wd;
    if (coef_re) begin
      coef_q_r  <= coef_mem[coef_ra];
      coef_qv_r <= coef_vld_r[coef_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (coef_we) begin
      coef_vld_r[coef_wa] <= 1'b1;
    end
  end

  assign coef_rd = coef_qv_r ? coef_q_r : 32'sd0;

  // accumulator port muxing
  always_comb begin
    bsum_re = cmd.u_rd || cmd.ub_rd || cmd.s_rd;
    bsum_ra = cmd.ub_rd ? BIAS_SLOT : cnt_r;
    bsum_we = cmd.u_acc || cmd.ub_acc || cmd.s_acc;
    bsum_wa = cmd.ub_acc ? BIAS_SLOT : cnt_r;
    if (cmd.u_acc) begin
      bsum_wd = lrbt_pkg::lrbt_sat48(49'(bsum_rd) + 49'(prod2_r >>> 8));
    end else if (cmd.ub_acc) begin
      bsum_wd = lrbt_pkg::lrbt_sat48(49'(bsum_rd) + 49'(err_r));
    end else begin
      bsum_wd = 48'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (bsum_we) bsum_mem[bsum_wa] <= bsum_wd;
    if (bsum_re) begin
      bsum_q_r  <= bsum_mem[bsum_ra];
      bsum_qv_r <= bsum_vld_r[bsum_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsum_vld_r <= '0;
    end else if (bsum_we) begin
      bsum_vld_r[bsum_wa] <= 1'b1;
    end
  end

  assign bsum_rd = bsum_qv_r ? bsum_q_r : 48'sd0;

  // feature buffer write and read
  always_ff @(posedge clk) begin
    if (cmd.f_rd) fst_mem[pos_r[FA_W-1:0]] <= x_r;
    if (cmd.u_rd) fst_q_r <= fst_mem[cnt_r[FA_W-1:0]];
  end

  // sigmoid table, built at elaboration
  logic [15:0] sig_tab [SIGMOID_ENTRIES];
  for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_sig
    localparam longint SIG_M =
      longint'((64'(2 * gi + 1) << 19) / SIGMOID_ENTRIES) - 64'sd524288;
    localparam logic [15:0] SIG_V = lrbt_pkg::lrbt_sig_entry(SIG_M);
    assign sig_tab[gi] = SIG_V;
  end

  // clamp z to [-8, 8) and index the table
  logic [19:0]    zc;
  logic [19:0]    zu;
  logic [SPW-1:0] sprod;
  logic [SIW-1:0] sidx;
  logic [15:0]    sig_val;
  always_comb begin
    if (z_r[47:19] != {29{z_r[47]}}) begin
      zc = z_r[47] ? {1'b1, 19'd0} : {1'b0, {19{1'b1}}};
    end else begin
      zc = z_r[19:0];
    end
    zu      = {~zc[19], zc[18:0]};
    sprod   = SPW'(zu) * SPW'(SIGMOID_ENTRIES);
    sidx    = sprod[20 +: SIW];
    sig_val = sig_tab[sidx];
  end

  // feature and update arithmetic
  always_ff @(posedge clk) begin
    if (cmd.f_mul) prod_r <= x_r * coef_rd;
    if (cmd.z_add) z_r <= lrbt_pkg::lrbt_sat48(49'(dot_r) + 49'(coef_rd));
    if (cmd.sig) begin
      err_r <= (truth_r ? 18'sd65536 : 18'sd0) - $signed({2'b00, sig_val});
      cls_r <= (z_r > 48'sd0);
    end
    if (cmd.u_mul) prod2_r <= fst_q_r * err_r;
    if (cmd.s_mul) begin
      pl_r <= $signed({1'b0, lr_r}) * $signed({1'b0, bsum_rd[23:0]});
      ph_r <= $signed({1'b0, lr_r}) * $signed(bsum_rd[47:24]);
    end
    if (cmd.s_init) begin
      total_r <= 48'sd0;
    end else if (cmd.s_acc) begin
      total_r <= lrbt_pkg::lrbt_sat48(49'(total_r) + 49'(diff));
    end
  end

  // position, dot sum and loop counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      dot_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.f_acc) begin
        dot_r <= lrbt_pkg::lrbt_sat48(49'(dot_r) + 49'(prod_r >>> 8));
        pos_r <= pos_r + 1'b1;
      end else if (cmd.ub_acc) begin
        dot_r <= '0;
        pos_r <= '0;
      end
      if (cmd.sig || cmd.s_init) begin
        cnt_r <= '0;
      end else if (cmd.u_acc || cmd.s_acc) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // confusion counters: tp, fp, fn, tn
  logic [1:0] oc;
  assign oc = cls_r ? (truth_r ? 2'd0 : 2'd1) : (truth_r ? 2'd2 : 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) cnts_r[i] <= '0;
    end else if (cmd.s_done) begin
      for (int i = 0; i < 4; i++) cnts_r[i] <= '0;
    end else if (cmd.ub_acc) begin
      for (int i = 0; i < 4; i++) begin
        if ((oc == 2'(i)) && (cnts_r[i] != 16'hFFFF)) cnts_r[i] <= cnts_r[i] + 1'b1;
      end
    end
  end

  // result staging
  logic [1:0]         res_kind_r;
  logic               res_cls_r;
  logic signed [31:0] res_coef_r;
  logic signed [47:0] res_total_r;
  logic [15:0]        res_cnt_r [4];

  always_ff @(posedge clk) begin
    if (cmd.ub_acc || cmd.s_done || cmd.r_done) begin
      res_cls_r   <= 1'b0;
      res_coef_r  <= '0;
      res_total_r <= '0;
      for (int i = 0; i < 4; i++) res_cnt_r[i] <= '0;
      if (cmd.ub_acc) begin
        res_kind_r <= lrbt_pkg::RESP_PRED;
        res_cls_r  <= cls_r;
      end else if (cmd.s_done) begin
        res_kind_r  <= lrbt_pkg::RESP_STEP;
        res_total_r <= total_r;
        for (int i = 0; i < 4; i++) res_cnt_r[i] <= cnts_r[i];
      end else begin
        res_kind_r <= lrbt_pkg::RESP_RDATA;
        res_coef_r <= cidx_ok ? coef_rd : 32'sd0;
      end
    end
  end

  // output register
  logic out_valid_r;
  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && out_free) begin
      out_resp_kind       <= res_kind_r;
      out_predicted_class <= res_cls_r;
      out_coeff_data      <= res_coef_r;
      out_total_change    <= res_total_r;
      out_true_pos        <= res_cnt_r[0];
      out_false_pos       <= res_cnt_r[1];
      out_false_neg       <= res_cnt_r[2];
      out_true_neg        <= res_cnt_r[3];
    end
  end

  assign out_valid = out_valid_r;

  // status
  always_comb begin
    sts          = '0;
    sts.req      = req_r;
    sts.last     = last_r;
    sts.pos_full = (pos_r == BIAS_SLOT);
    sts.pos_zero = (pos_r == '0);
    sts.u_last   = ((POS_W + 1)'(cnt_r) + 1'b1) == (POS_W + 1)'(pos_r);
    sts.s_last   = (cnt_r == BIAS_SLOT);
    sts.out_free = out_free;
  end

endmodule

FILE: rtl/core/logistic_regression_batch_trainer.sv
// Logistic regression trainer with batch gradient ascent. Requests are handled one at a
// time. A feature request is accepted and dispatched, then, unless the feature buffer
// is full, reads its coefficient, multiplies and accumulates. The request that ends an
// example then reads and adds the bias, looks up the sigmoid, runs an update pass of
// read, multiply and accumulator write-back per buffered feature, updates the bias
// accumulator and posts the prediction. A step request runs a pass of read, multiply and
// write-back per coefficient, then reports and posts. A coefficient read reads, reports
// and posts; a write is done at dispatch. A post waits while the output register holds
// an unaccepted result. Each memory is touched once per element per pass.
// Results sit in an output register; a new request is accepted while one waits there.
// Coefficients and accumulators clear at reset through valid bits, so no clearing pass.
module logistic_regression_batch_trainer #(
  parameter int SIGMOID_ENTRIES = lrbt_pkg::SIG_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  lrbt_in_if.sink     in_chan,
  lrbt_out_if.source  out_chan
);

  lrbt_pkg::lrbt_cmd_t cmd;
  lrbt_pkg::lrbt_sts_t sts;
  logic                in_ready;

  assign in_chan.ready = in_ready;

  // sequencer
  lrbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // memories and arithmetic
  lrbt_dp #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_chan.req_type),
    .in_feature_value    (in_chan.feature_value),
    .in_last_feature     (in_chan.last_feature),
    .in_truth            (in_chan.truth),
    .in_coeff_index      (in_chan.coeff_index),
    .in_coeff_value      (in_chan.coeff_value),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_resp_kind       (out_chan.resp_kind),
    .out_predicted_class (out_chan.predicted_class),
    .out_coeff_data      (out_chan.coeff_data),
    .out_total_change    (out_chan.total_change),
    .out_true_pos        (out_chan.true_pos),
    .out_false_pos       (out_chan.false_pos),
    .out_false_neg       (out_chan.false_neg),
    .out_true_neg        (out_chan.true_neg)
  );

  // a posted result shows up on the output
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && sts.out_free) |=> out_chan.valid)
    else $error("posted result not presented");

  // step write-back always follows its multiply
  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.s_acc |-> $past(cmd.s_mul))
    else $error("step write-back without multiply");

  // the feature buffer is never written past its end
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.f_rd |-> !sts.pos_full)
    else $error("feature buffer overrun");

  // no new request is taken while an update pass runs
  a_busy_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.u_acc || cmd.s_acc) |-> !in_chan.ready)
    else $error("request accepted during update pass");

endmodule

FILE: dv/lrbt_checker.sv
`timescale 1ns / 100ps

// watches both channels and the config port, predicts every result and compares
module lrbt_checker (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_wr_en,
  input  logic  [15:0] cfg_wr_data,
  lrbt_in_if    in_chan,
  lrbt_out_if   out_chan,
  output int    fail_count,
  output int    pending,
  output int    checked
);

  localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48 = -MAX48 - 1;
  localparam longint MAX32 = 64'sh0000_0000_7FFF_FFFF;
  localparam longint MIN32 = -MAX32 - 1;
  localparam int     SIG_N = lrbt_pkg::SIG_ENTRIES_DEF;
  localparam int     NV    = lrbt_pkg::NUM_VARS;

  typedef struct {
    logic [1:0]  kind;
    logic        cls;
    logic [31:0] cdata;
    logic [47:0] change;
    logic [15:0] cnt [4];
  } resp_t;

  resp_t        resp_q[$];
  longint       sig_lut [SIG_N];
  logic [15:0]  rate;
  longint       coef [NV + 1];
  longint       grad [NV + 1];
  longint       feat [NV];
  int           fpos;
  longint       acc;
  logic [15:0]  tally [4];

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // logistic value at Q16.16 point, series exp then repeated squaring
  function automatic longint logistic_at(longint m);
    longint unsigned a, y, y2, y3, p, e, d, s;
    a = (m < 0) ? -m : m;
    if (a == 0) begin
      e = 64'd1 << 32;
    end else begin
      y  = a << 8;
      y2 = (y * y) >> 32;
      y3 = (y2 * y) >> 32;
      p  = (64'd1 << 32) - y + y2 / 2 - y3 / 6;
      for (int k = 0; k < 8; k++) p = (p * p) >> 32;
      e = p;
    end
    d = (64'd1 << 32) + e;
    if (m >= 0) begin
      s = ((64'd1 << 48) + d / 2) / d;
      if (s > 65535) s = 65535;
    end else begin
      s = (e * 65536 + d / 2) / d;
    end
    return longint'(s);
  endfunction

  initial begin
    for (int i = 0; i < SIG_N; i++)
      sig_lut[i] = logistic_at(longint'(((64'd2 * i + 1) << 19) / SIG_N) - (64'sd1 << 19));
  end

  function automatic longint logistic(longint z);
    longint c;
    longint unsigned idx;
    c = clamp(z, -(64'sd1 << 19), (64'sd1 << 19) - 1);
    idx = (longint'(c + (64'sd1 << 19)) * SIG_N) >> 20;
    if (idx >= SIG_N) idx = SIG_N - 1;
    return sig_lut[idx];
  endfunction

  // advance the trainer state by one request, queue the result it causes
  task automatic train_request(logic [1:0] rq, logic signed [15:0] fv, logic lastf,
                               logic tr, logic [6:0] idx, logic signed [31:0] cv);
    resp_t  r;
    longint z, err, diff, total;
    int     slot;
    r.kind = lrbt_pkg::RESP_PRED;
    r.cls = 0;
    r.cdata = '0;
    r.change = '0;
    for (int k = 0; k < 4; k++) r.cnt[k] = '0;
    case (rq)
      lrbt_pkg::REQ_FEATURE: begin
        if (fpos < NV) begin
          feat[fpos] = longint'(fv);
          acc = clamp(acc + ((longint'(fv) * coef[fpos]) >>> 8), MIN48, MAX48);
          fpos++;
        end
        if (lastf) begin
          z = clamp(acc + coef[NV], MIN48, MAX48);
          err = (tr ? 65536 : 0) - logistic(z);
          for (int k = 0; k < fpos; k++)
            grad[k] = clamp(grad[k] + ((feat[k] * err) >>> 8), MIN48, MAX48);
          grad[NV] = clamp(grad[NV] + err, MIN48, MAX48);
          slot = (z > 0) ? (tr ? 0 : 1) : (tr ? 2 : 3);
          if (tally[slot] != 16'hFFFF) tally[slot]++;
          fpos = 0;
          acc = 0;
          r.cls = (z > 0);
          resp_q.push_back(r);
        end
      end
      lrbt_pkg::REQ_STEP: begin
        total = 0;
        for (int j = 0; j <= NV; j++) begin
          diff = (longint'({48'd0, rate}) * grad[j]) >>> 16;
          total = clamp(total + diff, MIN48, MAX48);
          coef[j] = clamp(coef[j] + diff, MIN32, MAX32);
          grad[j] = 0;
        end
        r.kind = lrbt_pkg::RESP_STEP;
        r.change = total[47:0];
        for (int k = 0; k < 4; k++) begin
          r.cnt[k] = tally[k];
          tally[k] = '0;
        end
        resp_q.push_back(r);
      end
      lrbt_pkg::REQ_WRITE: begin
        if (idx <= NV) coef[idx] = longint'(cv);
      end
      default: begin
        r.kind = lrbt_pkg::RESP_RDATA;
        if (idx <= NV) r.cdata = coef[idx][31:0];
        resp_q.push_back(r);
      end
    endcase
  endtask

  task automatic cmp(string fname, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    resp_t e;
    if (!rst_n) begin
      fail_count = 0;
      checked = 0;
      rate = lrbt_pkg::LR_RESET;
      for (int j = 0; j <= NV; j++) begin
        coef[j] = 0;
        grad[j] = 0;
      end
      fpos = 0;
      acc = 0;
      for (int k = 0; k < 4; k++) tally[k] = '0;
      resp_q.delete();
    end else begin
      if (cfg_wr_en) rate = cfg_wr_data;
      // compare a delivered result with the oldest prediction
      if (out_chan.valid && out_chan.ready) begin
        checked++;
        if (resp_q.size() == 0) begin
          $error("unexpected result, resp_kind %0d", out_chan.resp_kind);
          fail_count++;
        end else begin
          e = resp_q.pop_front();
          cmp("resp_kind", e.kind, out_chan.resp_kind);
          cmp("predicted_class", e.cls, out_chan.predicted_class);
          cmp("coeff_data", e.cdata, $unsigned(out_chan.coeff_data));
          cmp("total_change", e.change, $unsigned(out_chan.total_change));
          cmp("true_pos", e.cnt[0], out_chan.true_pos);
          cmp("false_pos", e.cnt[1], out_chan.false_pos);
          cmp("false_neg", e.cnt[2], out_chan.false_neg);
          cmp("true_neg", e.cnt[3], out_chan.true_neg);
        end
      end
      if (in_chan.valid && in_chan.ready)
        train_request(in_chan.req_type, in_chan.feature_value, in_chan.last_feature,
                      in_chan.truth, in_chan.coeff_index, in_chan.coeff_value);
    end
    pending = resp_q.size();
  end

endmodule

FILE: dv/logistic_regression_batch_trainer_test.sv
`timescale 1ns / 100ps

module logistic_regression_batch_trainer_test;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int NV          = lrbt_pkg::NUM_VARS;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  int          fail_count, pending, checked;
  int          cycles, sent;
  int          tx_idle_pct, rx_stall_pct;
  logic        hold_go, hold_prev;
  int          hold_cnt;

  lrbt_in_if  in_chan ();
  lrbt_out_if out_chan ();

  logistic_regression_batch_trainer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  lrbt_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    hold_prev <= hold_go;
    if (hold_go && !hold_prev) begin
      hold_cnt <= 400;
      out_chan.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // offer one request and wait until it is taken
  task automatic send(logic [1:0] rq, logic signed [15:0] fv, logic lastf, logic tr,
                      logic [6:0] idx, logic signed [31:0] cv);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.req_type      <= rq;
    in_chan.feature_value <= fv;
    in_chan.last_feature  <= lastf;
    in_chan.truth         <= tr;
    in_chan.coeff_index   <= idx;
    in_chan.coeff_value   <= cv;
    do @(posedge clk); while (!in_chan.ready);
    sent++;
  endtask

  task automatic feature(logic signed [15:0] fv, logic lastf, logic tr);
    send(lrbt_pkg::REQ_FEATURE, fv, lastf, tr, 7'($urandom), 32'($urandom));
  endtask

  task automatic coef_write(logic [6:0] idx, logic signed [31:0] cv);
    send(lrbt_pkg::REQ_WRITE, 16'($urandom), 1'($urandom), 1'($urandom), idx, cv);
  endtask

  task automatic coef_read(logic [6:0] idx);
    send(lrbt_pkg::REQ_READ, 16'($urandom), 1'($urandom), 1'($urandom), idx,
         32'($urandom));
  endtask

  task automatic step();
    send(lrbt_pkg::REQ_STEP, 16'($urandom), 1'($urandom), 1'($urandom), 7'($urandom),
         32'($urandom));
  endtask

  // let every prediction drain, then allow the last write to finish
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_rate(logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one example of n features, mostly reasonable magnitudes
  task automatic example(int n);
    logic tr;
    tr = 1'($urandom);
    for (int i = 0; i < n; i++)
      feature(($urandom_range(9) == 0) ? 16'($urandom) : 16'($signed($urandom_range(1023)) - 512),
              i == n - 1, tr);
  endtask

  // random mix, mostly complete examples with some stray requests
  task automatic random_mix(int count);
    int target, pick;
    target = sent + count;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 60) example(($urandom_range(19) == 0) ? $urandom_range(70, 60)
                                                      : $urandom_range(8, 1));
      else if (pick < 68) step();
      else if (pick < 78) coef_write(($urandom_range(7) == 0) ? 7'($urandom)
                                                              : 7'($urandom_range(NV)),
                                     ($urandom_range(3) == 0) ? $urandom
                                                              : $signed($urandom_range(8191)) - 4096);
      else if (pick < 90) coef_read(7'($urandom));
      else feature(16'($urandom), 1'b0, 1'($urandom));
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    sent = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_go = 0;
    hold_prev = 0;
    hold_cnt = 0;
    in_chan.valid = 0;
    in_chan.req_type = lrbt_pkg::REQ_FEATURE;
    in_chan.feature_value = 0;
    in_chan.last_feature = 0;
    in_chan.truth = 0;
    in_chan.coeff_index = 0;
    in_chan.coeff_value = 0;
    out_chan.ready = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: coefficient extremes, bad slots, feature extremes, long and short examples
    coef_read(7'(NV));
    coef_write(7'd0, 32'sh7FFF_FFFF);
    coef_write(7'd1, 32'sh8000_0000);
    coef_write(7'(NV), 32'sh0001_0000);
    coef_write(7'd100, 32'sh1234_5678);
    coef_read(7'd0);
    coef_read(7'd1);
    coef_read(7'd127);
    feature(16'sh7FFF, 1'b0, 1'b1);
    feature(16'sh8000, 1'b1, 1'b1);
    feature(16'sh8000, 1'b0, 1'b0);
    feature(16'sh7FFF, 1'b1, 1'b0);
    feature(16'sh0100, 1'b1, 1'b1);
    feature(16'sh0040, 1'b0, 1'b0);
    step();
    feature(16'sh0200, 1'b1, 1'b0);
    step();
    coef_read(7'd0);
    example(NV + 3);
    coef_write(7'd0, 32'sh0000_0000);
    coef_write(7'd1, 32'sh0000_0000);
    step();
    coef_read(7'(NV));

    // phase: no idling, learning rate at its top
    set_rate(16'hFFFF);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    random_mix(170);

    // phase: sparse sender, learning rate zero
    set_rate(16'h0000);
    tx_idle_pct = 87;
    rx_stall_pct = 0;
    random_mix(150);

    // phase: stalling receiver, with a long hold-off while features keep coming
    set_rate(16'($urandom));
    tx_idle_pct = 0;
    rx_stall_pct = 87;
    hold_go <= 1'b1;
    random_mix(40);
    hold_go <= 1'b0;
    random_mix(110);

    // sender waits for all pending results, then sends a short mix
    drain();
    random_mix(20);

    // phase: both sides idling, reset learning rate value
    set_rate(lrbt_pkg::LR_RESET);
    tx_idle_pct = 29;
    rx_stall_pct = 29;
    random_mix(240);
    step();

    drain();
    repeat (50) @(posedge clk);
    $display("sent %0d requests over four rate settings, checked %0d results", sent, checked);
    $display("covered coefficient extremes, bad slots, over-long examples and stalls");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: logistic_regression_batch_trainer.f
rtl/core/lrbt_pkg.sv
rtl/core/lrbt_if.sv
rtl/core/lrbt_ctrl.sv
rtl/core/lrbt_dp.sv
rtl/core/logistic_regression_batch_trainer.sv
dv/lrbt_checker.sv
dv/logistic_regression_batch_trainer_test.sv
